FILE: hdl/mmc3_pkg.sv
// Shared constants, codes and types for the MMC3 bank mapper register block.
package mmc3_pkg;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int WIN_W    = 3;
  localparam int BANK_W   = 9;
  localparam int IRQ_W    = 8;
  localparam int UNITS_W  = 8;

  localparam logic [UNITS_W-1:0] UNITS_RESET = 8'd16;

  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);

  localparam logic [ADDR_W-1:0] ADDR_BANK_SELECT = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [ADDR_W-1:0] ADDR_MIRRORING   = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_SRAM_PROT   = 16'hA001;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_LATCH   = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD  = 16'hC001;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_DISABLE = 16'hE000;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE  = 16'hE001;

  localparam logic [2:0] SEL_CHR_2K_LO  = 3'd0;
  localparam logic [2:0] SEL_CHR_2K_HI  = 3'd1;
  localparam logic [2:0] SEL_PRG_FIRST  = 3'd6;
  localparam logic [2:0] SEL_PRG_SECOND = 3'd7;

  localparam logic [WIN_W-1:0] PRG_WIN_0 = 3'd0;
  localparam logic [WIN_W-1:0] PRG_WIN_1 = 3'd1;
  localparam logic [WIN_W-1:0] PRG_WIN_2 = 3'd2;

  typedef struct packed {
    logic              update_valid;
    logic              target_chr;
    logic [WIN_W-1:0]  window_index;
    logic [BANK_W-1:0] bank_number;
    logic              mirror_horizontal;
    logic              sram_enabled;
    logic [IRQ_W-1:0]  irq_count;
    logic              irq_on;
    logic              last;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } wr_pkt_t;

endpackage

FILE: hdl/mmc3_ifs.sv
// Valid/ready channel interfaces for CPU write transactions and window update results.
interface mmc3_in_if;
  logic                          valid;
  logic                          ready;
  logic [mmc3_pkg::ADDR_W-1:0]   address;
  logic [mmc3_pkg::DATA_W-1:0]   data;

  modport source (output valid, output address, output data, input ready);
  modport sink   (input valid, input address, input data, output ready);
endinterface

interface mmc3_out_if;
  logic                          valid;
  logic                          ready;
  logic                          update_valid;
  logic                          target_chr;
  logic [mmc3_pkg::WIN_W-1:0]    window_index;
  logic [mmc3_pkg::BANK_W-1:0]   bank_number;
  logic                          mirror_horizontal;
  logic                          sram_enabled;
  logic [mmc3_pkg::IRQ_W-1:0]    irq_count;
  logic                          irq_on;
  logic                          last;

  modport source (output valid, output update_valid, output target_chr, output window_index,
                  output bank_number, output mirror_horizontal, output sram_enabled,
                  output irq_count, output irq_on, output last, input ready);
  modport sink   (input valid, input update_valid, input target_chr, input window_index,
                  input bank_number, input mirror_horizontal, input sram_enabled,
                  input irq_count, input irq_on, input last, output ready);
endinterface

FILE: hdl/mmc3_regs.sv
// Mapper register file and write decode producing one or two results (window updates or status) per write.
module mmc3_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mmc3_pkg::UNITS_W-1:0]      cfg_wr_data,
  input  logic                              wr_go,
  input  logic [mmc3_pkg::ADDR_W-1:0]       wr_address,
  input  logic [mmc3_pkg::DATA_W-1:0]       wr_data,
  output mmc3_pkg::wr_pkt_t                 pkt
);

  logic [mmc3_pkg::UNITS_W-1:0] units_r;
  logic [mmc3_pkg::DATA_W-1:0]  cmd_r, cmd_nxt;
  logic [mmc3_pkg::DATA_W-1:0]  prg_first_r, prg_first_nxt;
  logic                         prg_mode_r, prg_mode_nxt;
  logic                         chr_inv_r, chr_inv_nxt;
  logic [mmc3_pkg::IRQ_W-1:0]   irq_cnt_r, irq_cnt_nxt;
  logic [mmc3_pkg::IRQ_W-1:0]   irq_rld_r, irq_rld_nxt;
  logic                         irq_en_r, irq_en_nxt;
  logic                         mirror_r, mirror_nxt;
  logic                         sram_r, sram_nxt;

  logic [mmc3_pkg::BANK_W-1:0]  fixed_bank;
  logic [mmc3_pkg::BANK_W-1:0]  data_bank;
  logic [mmc3_pkg::BANK_W-1:0]  even_bank;
  logic [2:0]                   sel;
  logic [1:0]                   sel_1k;
  mmc3_pkg::result_t            r0, r1;
  logic                         two;

  assign fixed_bank = {units_r, 1'b0} - mmc3_pkg::BANK_W'(2);
  assign data_bank  = {1'b0, wr_data};
  assign even_bank  = {1'b0, wr_data[7:1], 1'b0};
  assign sel        = cmd_r[2:0];
  assign sel_1k     = sel[1:0] - 2'd2;

  always_comb begin
    cmd_nxt       = cmd_r;
    prg_first_nxt = prg_first_r;
    prg_mode_nxt  = prg_mode_r;
    chr_inv_nxt   = chr_inv_r;
    irq_cnt_nxt   = irq_cnt_r;
    irq_rld_nxt   = irq_rld_r;
    irq_en_nxt    = irq_en_r;
    mirror_nxt    = mirror_r;
    sram_nxt      = sram_r;
    r0            = '0;
    r1            = '0;
    two           = 1'b0;
    unique case (wr_address)
      mmc3_pkg::ADDR_BANK_SELECT: begin
        cmd_nxt      = wr_data;
        chr_inv_nxt  = wr_data[7];
        prg_mode_nxt = wr_data[6];
        if (wr_data[6] != prg_mode_r) begin
          two             = 1'b1;
          r0.update_valid = 1'b1;
          r1.update_valid = 1'b1;
          r0.bank_number  = fixed_bank;
          r1.bank_number  = {1'b0, prg_first_r};
          r0.window_index = wr_data[6] ? mmc3_pkg::PRG_WIN_0 : mmc3_pkg::PRG_WIN_2;
          r1.window_index = wr_data[6] ? mmc3_pkg::PRG_WIN_2 : mmc3_pkg::PRG_WIN_0;
        end
      end
      mmc3_pkg::ADDR_BANK_DATA: begin
        r0.update_valid = 1'b1;
        unique case (sel)
          mmc3_pkg::SEL_CHR_2K_LO, mmc3_pkg::SEL_CHR_2K_HI: begin
            two             = 1'b1;
            r1.update_valid = 1'b1;
            r0.target_chr   = 1'b1;
            r1.target_chr   = 1'b1;
            r0.window_index = {chr_inv_r, sel[0], 1'b0};
            r1.window_index = {chr_inv_r, sel[0], 1'b1};
            r0.bank_number  = even_bank;
            r1.bank_number  = even_bank | mmc3_pkg::BANK_W'(1);
          end
          mmc3_pkg::SEL_PRG_FIRST: begin
            prg_first_nxt   = wr_data;
            r0.window_index = cmd_r[6] ? mmc3_pkg::PRG_WIN_2 : mmc3_pkg::PRG_WIN_0;
            r0.bank_number  = data_bank;
          end
          mmc3_pkg::SEL_PRG_SECOND: begin
            r0.window_index = mmc3_pkg::PRG_WIN_1;
            r0.bank_number  = data_bank;
          end
          default: begin
            r0.target_chr   = 1'b1;
            r0.window_index = {~chr_inv_r, sel_1k};
            r0.bank_number  = data_bank;
          end
        endcase
      end
      mmc3_pkg::ADDR_MIRRORING: mirror_nxt = wr_data[0];
      mmc3_pkg::ADDR_SRAM_PROT: sram_nxt = sram_r | (wr_data != '0);
      mmc3_pkg::ADDR_IRQ_LATCH: begin
        if (!irq_en_r) begin
          irq_cnt_nxt = wr_data;
        end
      end
      mmc3_pkg::ADDR_IRQ_RELOAD: irq_rld_nxt = wr_data;
      mmc3_pkg::ADDR_IRQ_DISABLE: begin
        irq_cnt_nxt = irq_rld_r;
        irq_en_nxt  = 1'b0;
      end
      mmc3_pkg::ADDR_IRQ_ENABLE: irq_en_nxt = 1'b1;
      default: begin
      end
    endcase
    r0.mirror_horizontal = mirror_nxt;
    r0.sram_enabled      = sram_nxt;
    r0.irq_count         = irq_cnt_nxt;
    r0.irq_on            = irq_en_nxt;
    r0.last              = ~two;
    r1.mirror_horizontal = mirror_nxt;
    r1.sram_enabled      = sram_nxt;
    r1.irq_count         = irq_cnt_nxt;
    r1.irq_on            = irq_en_nxt;
    r1.last              = 1'b1;
  end

  assign pkt.two    = two;
  assign pkt.first  = r0;
  assign pkt.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r     <= mmc3_pkg::UNITS_RESET;
      cmd_r       <= '0;
      prg_first_r <= '0;
      prg_mode_r  <= 1'b0;
      chr_inv_r   <= 1'b0;
      irq_cnt_r   <= '0;
      irq_rld_r   <= '0;
      irq_en_r    <= 1'b0;
      mirror_r    <= 1'b0;
      sram_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        units_r <= cfg_wr_data;
      end
      if (wr_go) begin
        cmd_r       <= cmd_nxt;
        prg_first_r <= prg_first_nxt;
        prg_mode_r  <= prg_mode_nxt;
        chr_inv_r   <= chr_inv_nxt;
        irq_cnt_r   <= irq_cnt_nxt;
        irq_rld_r   <= irq_rld_nxt;
        irq_en_r    <= irq_en_nxt;
        mirror_r    <= mirror_nxt;
        sram_r      <= sram_nxt;
      end
    end
  end

endmodule

FILE: hdl/mmc3_result_fifo.sv
// Small result queue taking one or two results per push and draining one per cycle while out_if.ready is high.
module mmc3_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mmc3_pkg::wr_pkt_t pkt,
  output logic              room_two,
  mmc3_out_if.source        out_if
);

  mmc3_pkg::result_t            mem_r [mmc3_pkg::RES_DEPTH];
  logic [mmc3_pkg::PTR_W-1:0]   wp_r, wp_nxt;
  logic [mmc3_pkg::PTR_W-1:0]   rp_r, rp_nxt;
  logic [mmc3_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mmc3_pkg::CNT_W-1:0]   n_push;
  logic                         pop;
  mmc3_pkg::result_t            head;

  assign pop      = out_if.valid && out_if.ready;
  assign room_two = cnt_r <= mmc3_pkg::CNT_W'(mmc3_pkg::RES_DEPTH - 2);
  assign n_push   = push ? (pkt.two ? mmc3_pkg::CNT_W'(2) : mmc3_pkg::CNT_W'(1))
                         : '0;
  assign wp_nxt   = wp_r + n_push[mmc3_pkg::PTR_W-1:0];
  assign rp_nxt   = rp_r + mmc3_pkg::PTR_W'(pop);
  assign cnt_nxt  = cnt_r + n_push - mmc3_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= pkt.first;
      if (pkt.two) begin
        mem_r[wp_r + mmc3_pkg::PTR_W'(1)] <= pkt.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head                     = mem_r[rp_r];
  assign out_if.valid             = cnt_r != '0;
  assign out_if.update_valid      = head.update_valid;
  assign out_if.target_chr        = head.target_chr;
  assign out_if.window_index      = head.window_index;
  assign out_if.bank_number       = head.bank_number;
  assign out_if.mirror_horizontal = head.mirror_horizontal;
  assign out_if.sram_enabled      = head.sram_enabled;
  assign out_if.irq_count         = head.irq_count;
  assign out_if.irq_on            = head.irq_on;
  assign out_if.last              = head.last;

endmodule

FILE: hdl/mmc3_bank_mapper_registers.sv
// Top level of the MMC3 bank mapper register block: input stage, decode and result queue.
//
//   channel  direction  transaction                      payload
//   in_if    sink       one CPU write                    address[15:0], data[7:0]
//   out_if   source     one window update or status      update_valid .. last
//   cfg_*    write      PRG ROM size in 16KB units       cfg_wr_data[7:0]
//
// A write is captured in the input stage on acceptance and decoded from there once the
// four-entry queue has room for two results; its results are then written into the queue.
// The queue has a single read port, so writes that make two updates fill it faster than
// it drains, and the input stage and in_if.ready are then held.
// Reset clears all mapper state and sets the ROM size to 16 units.
// Stalls at out_if fill the queue, then hold the input stage and in_if.ready.
module mmc3_bank_mapper_registers (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [mmc3_pkg::UNITS_W-1:0]  cfg_wr_data,
  mmc3_in_if.sink                       in_if,
  mmc3_out_if.source                    out_if
);

  logic                         stage_vld_r;
  logic [mmc3_pkg::ADDR_W-1:0]  stage_addr_r;
  logic [mmc3_pkg::DATA_W-1:0]  stage_data_r;
  logic                         room_two;
  logic                         proc_go;
  logic                         in_fire;
  mmc3_pkg::wr_pkt_t            pkt;

  assign proc_go     = stage_vld_r && room_two;
  assign in_if.ready = !stage_vld_r || proc_go;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      stage_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_addr_r <= in_if.address;
      stage_data_r <= in_if.data;
    end
  end

  mmc3_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_go       (proc_go),
    .wr_address  (stage_addr_r),
    .wr_data     (stage_data_r),
    .pkt         (pkt)
  );

  mmc3_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (proc_go),
    .pkt      (pkt),
    .room_two (room_two),
    .out_if   (out_if)
  );

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> stage_vld_r)
    else $error("accepted transaction did not reach the input stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stage_vld_r && !proc_go |=> stage_vld_r && $stable(stage_addr_r) && $stable(stage_data_r))
    else $error("stalled input stage changed");

  a_decode_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |=> out_if.valid)
    else $error("decoded write left no result in the queue");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid && !stage_vld_r)
    else $error("reset left results pending");

endmodule
